FILE: rtl/kpdc_pkg.sv
// Package for the key press duration classifier: counter width, thresholds,
// press state codes and the structs passed between the top level and the step logic.
// No dependencies.
package kpdc_pkg;

  // Down-tick counter width (valid range 4 to 16).
  localparam int unsigned COUNT_WIDTH = 8;
  // Threshold register width, fixed by the register map.
  localparam int unsigned THR_WIDTH   = 8;
  // Compare width that holds both the counter and a threshold.
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration register indexes.
  localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] REG_LONG      = 2'd1;
  localparam logic [1:0] REG_VERY_LONG = 2'd2;

  // Reset values of the thresholds.
  localparam logic [THR_WIDTH-1:0] DEBOUNCE_RESET  = 8'd3;
  localparam logic [THR_WIDTH-1:0] LONG_RESET      = 8'd40;
  localparam logic [THR_WIDTH-1:0] VERY_LONG_RESET = 8'd120;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_LONG    = 2'd2,
    ST_VLONG   = 2'd3
  } press_state_t;

  typedef struct packed {
    logic [THR_WIDTH-1:0] debounce_ticks;
    logic [THR_WIDTH-1:0] long_ticks;
    logic [THR_WIDTH-1:0] very_long_ticks;
  } kpdc_cfg_t;

  typedef struct packed {
    logic         short_press;
    logic         long_press;
    logic         very_long_press;
    press_state_t press_level;
  } kpdc_result_t;

endpackage

FILE: rtl/kpdc_step.sv
// Next-state and event logic for one key sample of the classifier.
// Depends on kpdc_pkg.
module kpdc_step (
  input  logic                             key_down,
  input  kpdc_pkg::press_state_t           state_cur,
  input  logic [kpdc_pkg::COUNT_WIDTH-1:0] count_cur,
  input  kpdc_pkg::kpdc_cfg_t              cfg,
  output kpdc_pkg::press_state_t           state_nxt,
  output logic [kpdc_pkg::COUNT_WIDTH-1:0] count_nxt,
  output kpdc_pkg::kpdc_result_t           result
);
  import kpdc_pkg::*;

  logic [COUNT_WIDTH-1:0] count_up;
  logic [CMP_WIDTH-1:0]   up_ext;
  logic [CMP_WIDTH-1:0]   cur_ext;
  logic [CMP_WIDTH-1:0]   deb_ext;
  logic [CMP_WIDTH-1:0]   long_ext;
  logic [CMP_WIDTH-1:0]   vlong_ext;
  logic                   short_p;
  logic                   long_p;
  logic                   vlong_p;

  // Saturate rather than wrap.
  assign count_up  = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;

  assign up_ext    = CMP_WIDTH'(count_up);
  assign cur_ext   = CMP_WIDTH'(count_cur);
  assign deb_ext   = CMP_WIDTH'(cfg.debounce_ticks);
  assign long_ext  = CMP_WIDTH'(cfg.long_ticks);
  assign vlong_ext = CMP_WIDTH'(cfg.very_long_ticks);

  always_comb begin
    state_nxt = state_cur;
    count_nxt = count_cur;
    short_p   = 1'b0;
    long_p    = 1'b0;
    vlong_p   = 1'b0;
    if (key_down) begin
      case (state_cur)
        ST_IDLE: begin
          count_nxt = count_up;
          if (up_ext > deb_ext) state_nxt = ST_PRESSED;
        end
        ST_PRESSED: begin
          count_nxt = count_up;
          if (up_ext > long_ext) begin
            state_nxt = ST_LONG;
            long_p    = 1'b1;
          end
        end
        ST_LONG: begin
          count_nxt = count_up;
          if (up_ext > vlong_ext) begin
            state_nxt = ST_VLONG;
            vlong_p   = 1'b1;
          end
        end
        default: begin
          // hold the count in the very long state
          count_nxt = count_cur;
        end
      endcase
    end else begin
      case (state_cur)
        ST_PRESSED: begin
          if (cur_ext > deb_ext) begin
            state_nxt = ST_IDLE;
            short_p   = 1'b1;
          end
        end
        ST_LONG, ST_VLONG: begin
          state_nxt = ST_IDLE;
        end
        default: begin
          state_nxt = state_cur;
        end
      endcase
      count_nxt = '0;
    end
  end

  assign result.short_press     = short_p;
  assign result.long_press      = long_p;
  assign result.very_long_press = vlong_p;
  assign result.press_level     = state_nxt;

endmodule

FILE: rtl/key_press_duration_classifier.sv
// Top level of the key press duration classifier: threshold registers, press
// state and down counter, and the result register. Depends on kpdc_pkg and kpdc_step.
//
// One key sample is taken per input transaction and gives exactly one result
// transaction: short, long and very-long event pulses plus the press level after
// that sample. The block takes one transaction every clock cycle unless the output
// stalls; the result appears in the output register in the cycle after acceptance.
// The rate is set by the loop through the press state and down counter registers.
// The input side stays ready while the result register is empty or being emptied
// in the same cycle, so a stalled output halts intake only once its register is full.
// Thresholds are written through the cfg_ port; the user must do so only while no
// transaction is in flight, not enforced by the block; unknown indexes are ignored.
module key_press_duration_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_key_down,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_short_press,
  output logic       out_long_press,
  output logic       out_very_long_press,
  output logic [1:0] out_press_level
);
  import kpdc_pkg::*;

  kpdc_cfg_t              cfg_r;
  press_state_t           state_r;
  press_state_t           state_nxt;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  kpdc_result_t           result_nxt;
  kpdc_result_t           result_r;
  logic                   out_valid_r;
  logic                   in_fire;

  // accept while the result register is free or draining this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Threshold registers: write at once, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= DEBOUNCE_RESET;
      cfg_r.long_ticks      <= LONG_RESET;
      cfg_r.very_long_ticks <= VERY_LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:  cfg_r.debounce_ticks  <= cfg_wdata;
        REG_LONG:      cfg_r.long_ticks      <= cfg_wdata;
        REG_VERY_LONG: cfg_r.very_long_ticks <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  kpdc_step u_step (
    .key_down  (in_key_down),
    .state_cur (state_r),
    .count_cur (count_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .count_nxt (count_nxt),
    .result    (result_nxt)
  );

  // Advance the press state and counter only on an accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register: load on acceptance, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_short_press     = result_r.short_press;
  assign out_long_press      = result_r.long_press;
  assign out_very_long_press = result_r.very_long_press;
  assign out_press_level     = result_r.press_level;

endmodule

FILE: test/kpdc_checker.sv
// Checker for the key press duration classifier: tracks the threshold writes,
// predicts one result per key sample and compares it with the result channel.
// Depends on kpdc_pkg.
module kpdc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_key_down,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_short_press,
  input  logic       out_long_press,
  input  logic       out_very_long_press,
  input  logic [1:0] out_press_level,
  output int         fail_count,
  output int         pending,
  output int         short_seen,
  output int         long_seen,
  output int         very_long_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import kpdc_pkg::*;

  logic [THR_WIDTH-1:0]   debounce_thr;
  logic [THR_WIDTH-1:0]   long_thr;
  logic [THR_WIDTH-1:0]   very_long_thr;
  press_state_t           level_q;
  logic [COUNT_WIDTH-1:0] held_ticks;
  kpdc_result_t           expected_q[$];

  // Advance the press state by one key sample and return the events it raises.
  function automatic kpdc_result_t classify_tick(input logic key);
    kpdc_result_t r;
    r = '0;
    if (key) begin
      // the counter holds in very long and sticks at its maximum
      if (level_q != ST_VLONG && held_ticks != COUNT_MAX) held_ticks = held_ticks + 1'b1;
      case (level_q)
        ST_IDLE: begin
          if (held_ticks > debounce_thr) level_q = ST_PRESSED;
        end
        ST_PRESSED: begin
          if (held_ticks > long_thr) begin
            level_q = ST_LONG;
            r.long_press = 1'b1;
          end
        end
        ST_LONG: begin
          if (held_ticks > very_long_thr) begin
            level_q = ST_VLONG;
            r.very_long_press = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (level_q)
        ST_PRESSED: begin
          // a raised debounce threshold can leave the press standing
          if (held_ticks > debounce_thr) begin
            level_q = ST_IDLE;
            r.short_press = 1'b1;
          end
        end
        ST_LONG, ST_VLONG: level_q = ST_IDLE;
        default: ;
      endcase
      held_ticks = '0;
    end
    r.press_level = level_q;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    kpdc_result_t want;
    if (!rst_n) begin
      debounce_thr  = DEBOUNCE_RESET;
      long_thr      = LONG_RESET;
      very_long_thr = VERY_LONG_RESET;
      level_q       = ST_IDLE;
      held_ticks    = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:  debounce_thr  = cfg_wdata;
          REG_LONG:      long_thr      = cfg_wdata;
          REG_VERY_LONG: very_long_thr = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: expected no result, actual short %b long %b very long %b level %0d",
                   $time, out_short_press, out_long_press, out_very_long_press,
                   out_press_level);
        end else begin
          want = expected_q.pop_front();
          check_field("short_press", int'(want.short_press), int'(out_short_press));
          check_field("long_press", int'(want.long_press), int'(out_long_press));
          check_field("very_long_press", int'(want.very_long_press),
                      int'(out_very_long_press));
          check_field("press_level", int'(want.press_level), int'(out_press_level));
          short_seen     += int'(want.short_press);
          long_seen      += int'(want.long_press);
          very_long_seen += int'(want.very_long_press);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(classify_tick(in_key_down));
    end
    pending <= expected_q.size();
  end

endmodule

FILE: test/tb_key_press_duration_classifier.sv
// Testbench top for the key press duration classifier: clock, reset, key sample
// stimulus, threshold programming, output back-pressure and the verdict.
// Depends on kpdc_pkg, key_press_duration_classifier and kpdc_checker.
module tb_key_press_duration_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import kpdc_pkg::*;

  localparam int         CLK_HALF       = 10;
  localparam int         ITEM_TARGET    = 1850;
  localparam int         CALM_TAIL      = 200;   // final samples with no idling
  localparam int         PHASE_ITEMS    = 150;   // samples per threshold setting
  localparam int         SETTLE_CYCLES  = 4;     // output register latency plus margin
  localparam int         WATCHDOG_LIMIT = 500;
  localparam logic [1:0] REG_SPARE      = 2'd3;  // beyond the register map

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [1:0] cfg_index   = REG_DEBOUNCE;
  logic [7:0] cfg_wdata   = 8'd0;
  logic       in_valid    = 1'b0;
  logic       in_key_down = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_short_press;
  logic       out_long_press;
  logic       out_very_long_press;
  logic [1:0] out_press_level;

  int fail_count;
  int pending;
  int short_seen;
  int long_seen;
  int very_long_seen;
  int sent;
  int settings;
  int tx_gap_pct;
  int rx_stall_pct;
  int rx_stall_left;
  int quiet_cycles;
  int cur_deb;
  int cur_long;
  int cur_vlong;
  bit calm;

  always #(CLK_HALF) clk = ~clk;

  key_press_duration_classifier dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_down         (in_key_down),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_short_press     (out_short_press),
    .out_long_press      (out_long_press),
    .out_very_long_press (out_very_long_press),
    .out_press_level     (out_press_level)
  );

  kpdc_checker kpdc_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_down         (in_key_down),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_short_press     (out_short_press),
    .out_long_press      (out_long_press),
    .out_very_long_press (out_very_long_press),
    .out_press_level     (out_press_level),
    .fail_count          (fail_count),
    .pending             (pending),
    .short_seen          (short_seen),
    .long_seen           (long_seen),
    .very_long_seen      (very_long_seen)
  );

  // Result side back-pressure: stall in bursts of random length, never in the calm tail.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      out_ready     <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_ready     <= 1'b0;
      rx_stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction moves on any port.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending);
      $display("key_press_duration_classifier: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one key sample and hold it until the block takes it. Idle the input
  // side first now and then, except in the calm tail.
  task automatic send_tick(input logic key);
    int gap;
    calm = (sent >= ITEM_TARGET - CALM_TAIL);
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_key_down <= key;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic hold_and_release(input int downs, input int ups);
    repeat (downs) send_tick(1'b1);
    repeat (ups) send_tick(1'b0);
  endtask

  // Drop valid, wait for every outstanding result, then let the output register
  // settle. The first edge lets the checker count the last transaction.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program all three thresholds while idle, plus a write to the unused index
  // that the block must ignore. The press state carries over untouched.
  task automatic set_thresholds(input logic [7:0] deb, input logic [7:0] lng,
                                input logic [7:0] vlng);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= REG_LONG;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_index <= REG_VERY_LONG;
    cfg_wdata <= vlng;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_deb   = deb;
    cur_long  = lng;
    cur_vlong = vlng;
    settings++;
  endtask

  // Mostly small thresholds keep holds short; the extremes turn up regularly.
  function automatic logic [7:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd254;
      2:       return 8'($urandom_range(0, 254));
      default: return 8'($urandom_range(0, 20));
    endcase
  endfunction

  // One random press aimed near a stage boundary, or a burst of contact bounce.
  task automatic random_press();
    int base;
    int downs;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
    end else begin
      case ($urandom_range(0, 3))
        0:       base = cur_deb;
        1:       base = cur_deb + 1;
        2:       base = ((cur_deb > cur_long) ? cur_deb : cur_long) + 2;
        default: begin
          base = (cur_deb > cur_long) ? cur_deb : cur_long;
          base = ((base > cur_vlong) ? base : cur_vlong) + 3;
        end
      endcase
      downs = base - 1 + $urandom_range(0, 3);
      if (downs < 1) downs = 1;
      hold_and_release(downs, $urandom_range(1, 3));
    end
  endtask

  initial begin
    int phase_end;
    cur_deb   = DEBOUNCE_RESET;
    cur_long  = LONG_RESET;
    cur_vlong = VERY_LONG_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset thresholds first, then the corners.
    send_tick(1'b0);                  // release while idle
    hold_and_release(5, 1);           // short press at the reset thresholds
    set_thresholds(8'd0, 8'd0, 8'd0); // zero thresholds, stages on successive ticks
    hold_and_release(4, 1);           // through very long and back, no release pulse
    set_thresholds(8'd0, 8'd2, 8'd254);
    hold_and_release(4, 1);           // release from long gives nothing
    set_thresholds(8'd0, 8'd254, 8'd254);
    hold_and_release(2, 0);           // leave the press standing
    set_thresholds(8'd10, 8'd254, 8'd254);
    send_tick(1'b0);                  // release below the raised debounce: stays pressed
    hold_and_release(1, 1);
    set_thresholds(8'd0, 8'd254, 8'd254);
    hold_and_release(1, 1);           // now a short press

    // Random: first setting at the top of the range to drive the counter into
    // saturation, then random settings with random idling per setting.
    set_thresholds(8'd254, 8'd254, 8'd254);
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 10;
        default: tx_gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 10;
        default: rx_stall_pct = 30;
      endcase
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < ITEM_TARGET) random_press();
      if (sent < ITEM_TARGET) set_thresholds(pick_threshold(), pick_threshold(),
                                             pick_threshold());
    end

    wait_idle();
    $display("%0d key samples over %0d threshold settings checked", sent, settings);
    $display("events seen: %0d short, %0d long, %0d very long",
             short_seen, long_seen, very_long_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("key_press_duration_classifier: match");
    end else begin
      $display("key_press_duration_classifier: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/kpdc_pkg.sv
rtl/kpdc_step.sv
rtl/key_press_duration_classifier.sv
test/kpdc_checker.sv
test/tb_key_press_duration_classifier.sv
